@@ hw/rtl/slab_slot_allocator_top_macros.svh @@
// Assertion helpers for the RTL file that checks its own logic.
`ifndef SLAB_SLOT_ALLOCATOR_TOP_MACROS_SVH
`define SLAB_SLOT_ALLOCATOR_TOP_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define SSA_CHECK(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Antecedent implies consequent in the next clock cycle.
`define SSA_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/ssa_pkg.sv @@
`timescale 1ns / 1ps
package ssa_pkg;

    localparam int MAX_PAGES      = 16;
    localparam int SLOTS_PER_PAGE = 64;
    localparam int PAGE_W         = 4;
    localparam int SLOT_W         = 6;
    localparam int CNT_W          = 7;
    localparam int LIST_W         = 5;
    localparam int ADDR_W         = PAGE_W + SLOT_W;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_NO_FRAME     = 2'd1,
        ST_NOT_LISTED   = 2'd2,
        ST_ALREADY_FREE = 2'd3
    } status_t;

    localparam logic [1:0] CFG_FIT_MODE   = 2'd0;
    localparam logic [1:0] CFG_KEEP_LAST  = 2'd1;
    localparam logic [1:0] CFG_THRESHOLD  = 2'd2;
    localparam logic [1:0] CFG_SLOTS      = 2'd3;

    typedef struct packed {
        logic                stk_we;
        logic [ADDR_W-1:0]   stk_waddr;
        logic [SLOT_W-1:0]   stk_wdata;
        logic [ADDR_W-1:0]   stk_raddr;
        logic                free_we;
        logic [ADDR_W-1:0]   free_waddr;
        logic                free_wdata;
        logic [ADDR_W-1:0]   free_raddr;
    } mem_req_t;

endpackage

@@ hw/rtl/slab_slot_allocator_top.sv @@
`timescale 1ns / 1ps
// Channel   Direction  tdata (low bit up)                          tuser (low bit up)
// s_axis    in         page_id[3:0], slot_index[9:4]               func[0], hint_valid[1]
// m_axis    out        granted_page[3:0], granted_slot[9:4],       status[1:0]
//                      page_released[10]
// cfg       in         cfg_we, cfg_addr (register index), cfg_wdata
//
// One request at a time; the page-list walk (one entry a cycle, up to 16) and the
// fill of a new page's slot stack through the slot memory set how long it takes.
// Release of the last slot adds a list walk and a compaction pass, unless keep-last
// is set and only one page is listed.
// Reset is synchronous on aresetn; the slot memories need no clearing pass.
// A result waiting on m_axis does not block acceptance of the next request.
`include "slab_slot_allocator_top_macros.svh"
module slab_slot_allocator_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // page_id[3:0], slot_index[9:4]
    input  logic [1:0]  s_axis_tuser,   // func[0], hint_valid[1]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // granted_page[3:0], granted_slot[9:4], page_released[10]
    output logic [1:0]  m_axis_tuser,   // status[1:0]
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [6:0]  cfg_wdata
);

    localparam int NP = ssa_pkg::MAX_PAGES;

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_SCAN, S_FIND, S_NBR_NEXT, S_NBR_PREV, S_NEWPAGE,
        S_INIT, S_POP, S_POP_DONE, S_REL_CHK, S_COMPACT, S_RESP
    } state_t;

    state_t state_reg;

    logic                        ff_reg, keep_reg;
    logic [5:0]                  thr_reg;
    logic [ssa_pkg::CNT_W-1:0]   siu_reg;

    logic [ssa_pkg::PAGE_W-1:0]  order_reg [NP];
    logic [ssa_pkg::CNT_W-1:0]   fsc_reg [NP];
    logic [ssa_pkg::CNT_W-1:0]   cap_reg [NP];
    logic [ssa_pkg::LIST_W-1:0]  listed_reg;
    logic [NP-1:0]               busy_reg;

    logic                        rel_reg, hint_reg;
    logic [ssa_pkg::PAGE_W-1:0]  pid_reg;
    logic [ssa_pkg::SLOT_W-1:0]  slot_in_reg;

    logic [ssa_pkg::LIST_W-1:0]  idx_reg;
    logic [ssa_pkg::PAGE_W-1:0]  frame_reg, best_frame_reg;
    logic [ssa_pkg::CNT_W-1:0]   best_cnt_reg;
    logic                        best_found_reg;
    logic [ssa_pkg::CNT_W-1:0]   sw_reg;

    ssa_pkg::status_t            res_status_reg;
    logic [ssa_pkg::PAGE_W-1:0]  res_page_reg;
    logic [ssa_pkg::SLOT_W-1:0]  res_slot_reg;
    logic                        res_rel_reg;

    logic                        m_valid_reg;
    ssa_pkg::status_t            out_status_reg;
    logic [ssa_pkg::PAGE_W-1:0]  out_page_reg;
    logic [ssa_pkg::SLOT_W-1:0]  out_slot_reg;
    logic                        out_rel_reg;

    ssa_pkg::mem_req_t           mem_req;
    logic [ssa_pkg::SLOT_W-1:0]  stk_rdata;
    logic                        free_rdata;

    logic [ssa_pkg::PAGE_W-1:0]  free_frame;
    logic                        have_free;
    logic [ssa_pkg::CNT_W-1:0]   eff_slots;
    logic [ssa_pkg::PAGE_W-1:0]  scan_frame, next_frame, prev_frame;
    logic [ssa_pkg::CNT_W-1:0]   scan_cnt, pop_cnt, rel_cnt;
    logic [ssa_pkg::LIST_W-1:0]  idx_plus, pos_minus;
    logic                        s_accept;

    ssa_slot_mem u_mem (
        .aclk       (aclk),
        .req        (mem_req),
        .stk_rdata  (stk_rdata),
        .free_rdata (free_rdata)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {5'd0, out_rel_reg, out_slot_reg, out_page_reg};

    always_comb begin
        free_frame = '0;
        have_free  = 1'b0;
        for (int k = NP - 1; k >= 0; k--) begin
            if (!busy_reg[k]) begin
                free_frame = ssa_pkg::PAGE_W'(k);
                have_free  = 1'b1;
            end
        end
    end

    always_comb begin
        if (siu_reg == '0) begin
            eff_slots = ssa_pkg::CNT_W'(1);
        end else if (siu_reg > ssa_pkg::CNT_W'(ssa_pkg::SLOTS_PER_PAGE)) begin
            eff_slots = ssa_pkg::CNT_W'(ssa_pkg::SLOTS_PER_PAGE);
        end else begin
            eff_slots = siu_reg;
        end
    end

    assign idx_plus   = idx_reg + ssa_pkg::LIST_W'(1);
    assign pos_minus  = idx_reg - ssa_pkg::LIST_W'(1);
    assign scan_frame = order_reg[idx_reg[ssa_pkg::PAGE_W-1:0]];
    assign next_frame = order_reg[idx_plus[ssa_pkg::PAGE_W-1:0]];
    assign prev_frame = order_reg[pos_minus[ssa_pkg::PAGE_W-1:0]];
    assign scan_cnt   = fsc_reg[scan_frame];
    assign pop_cnt    = fsc_reg[frame_reg];
    assign rel_cnt    = fsc_reg[pid_reg];

    always_comb begin
        mem_req            = '0;
        mem_req.stk_raddr  = {frame_reg, pop_cnt[ssa_pkg::SLOT_W-1:0] - ssa_pkg::SLOT_W'(1)};
        mem_req.free_raddr = {pid_reg, slot_in_reg};
        unique case (state_reg)
            S_INIT: begin
                mem_req.stk_we     = 1'b1;
                mem_req.stk_waddr  = {frame_reg, sw_reg[ssa_pkg::SLOT_W-1:0]};
                mem_req.stk_wdata  = sw_reg[ssa_pkg::SLOT_W-1:0];
                mem_req.free_we    = 1'b1;
                mem_req.free_waddr = {frame_reg, sw_reg[ssa_pkg::SLOT_W-1:0]};
                mem_req.free_wdata = (sw_reg < cap_reg[frame_reg]);
            end
            S_POP_DONE: begin
                mem_req.free_we    = 1'b1;
                mem_req.free_waddr = {frame_reg, stk_rdata};
                mem_req.free_wdata = 1'b0;
            end
            S_REL_CHK: begin
                mem_req.stk_we     = !free_rdata &&
                                     (rel_cnt < ssa_pkg::CNT_W'(ssa_pkg::SLOTS_PER_PAGE));
                mem_req.stk_waddr  = {pid_reg, rel_cnt[ssa_pkg::SLOT_W-1:0]};
                mem_req.stk_wdata  = slot_in_reg;
                mem_req.free_we    = !free_rdata;
                mem_req.free_waddr = {pid_reg, slot_in_reg};
                mem_req.free_wdata = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            ff_reg      <= 1'b1;
            keep_reg    <= 1'b0;
            thr_reg     <= '0;
            siu_reg     <= ssa_pkg::CNT_W'(64);
            listed_reg  <= '0;
            busy_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    ssa_pkg::CFG_FIT_MODE:  ff_reg   <= cfg_wdata[0];
                    ssa_pkg::CFG_KEEP_LAST: keep_reg <= cfg_wdata[0];
                    ssa_pkg::CFG_THRESHOLD: thr_reg  <= cfg_wdata[5:0];
                    ssa_pkg::CFG_SLOTS:     siu_reg  <= cfg_wdata;
                endcase
            end
            // the response state reloads the output itself
            if (m_valid_reg && m_axis_tready && state_reg != S_RESP) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        rel_reg        <= s_axis_tuser[0];
                        hint_reg       <= s_axis_tuser[1];
                        pid_reg        <= s_axis_tdata[3:0];
                        slot_in_reg    <= s_axis_tdata[9:4];
                        res_status_reg <= ssa_pkg::ST_OK;
                        res_page_reg   <= '0;
                        res_slot_reg   <= '0;
                        res_rel_reg    <= 1'b0;
                        idx_reg        <= '0;
                        best_found_reg <= 1'b0;
                        best_cnt_reg   <= '1;
                        state_reg      <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    if (rel_reg) begin
                        if (!busy_reg[pid_reg] || slot_in_reg >= cap_reg[pid_reg]) begin
                            res_status_reg <= ssa_pkg::ST_NOT_LISTED;
                            state_reg      <= S_RESP;
                        end else begin
                            state_reg <= S_REL_CHK;
                        end
                    end else if (listed_reg == '0) begin
                        state_reg <= S_NEWPAGE;
                    end else if (hint_reg) begin
                        if (!busy_reg[pid_reg]) begin
                            state_reg <= S_NEWPAGE;
                        end else if (fsc_reg[pid_reg] != '0) begin
                            frame_reg <= pid_reg;
                            state_reg <= S_POP;
                        end else if (ff_reg) begin
                            state_reg <= S_SCAN;
                        end else begin
                            state_reg <= S_FIND;
                        end
                    end else begin
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (idx_reg < listed_reg) begin
                        idx_reg <= idx_plus;
                        if (scan_cnt > ssa_pkg::CNT_W'(thr_reg)) begin
                            if (ff_reg) begin
                                frame_reg <= scan_frame;
                                state_reg <= S_POP;
                            end else if (scan_cnt < best_cnt_reg) begin
                                best_cnt_reg   <= scan_cnt;
                                best_frame_reg <= scan_frame;
                                best_found_reg <= 1'b1;
                                // exact fit: stop early
                                if (scan_cnt == ssa_pkg::CNT_W'(thr_reg) +
                                                ssa_pkg::CNT_W'(1)) begin
                                    frame_reg <= scan_frame;
                                    state_reg <= S_POP;
                                end
                            end
                        end
                    end else if (best_found_reg) begin
                        frame_reg <= best_frame_reg;
                        state_reg <= S_POP;
                    end else begin
                        state_reg <= S_NEWPAGE;
                    end
                end
                S_FIND: begin
                    if (scan_frame == pid_reg || idx_plus >= listed_reg) begin
                        state_reg <= rel_reg ? S_COMPACT : S_NBR_NEXT;
                    end else begin
                        idx_reg <= idx_plus;
                    end
                end
                S_NBR_NEXT: begin
                    if (idx_plus < listed_reg && fsc_reg[next_frame] != '0) begin
                        frame_reg <= next_frame;
                        state_reg <= S_POP;
                    end else begin
                        state_reg <= S_NBR_PREV;
                    end
                end
                S_NBR_PREV: begin
                    if (idx_reg != '0 && fsc_reg[prev_frame] != '0) begin
                        frame_reg <= prev_frame;
                        state_reg <= S_POP;
                    end else begin
                        idx_reg   <= '0;
                        state_reg <= S_SCAN;
                    end
                end
                S_NEWPAGE: begin
                    if (listed_reg >= ssa_pkg::LIST_W'(NP) || !have_free) begin
                        res_status_reg <= ssa_pkg::ST_NO_FRAME;
                        state_reg      <= S_RESP;
                    end else begin
                        busy_reg[free_frame] <= 1'b1;
                        cap_reg[free_frame]  <= eff_slots;
                        fsc_reg[free_frame]  <= eff_slots;
                        order_reg[listed_reg[ssa_pkg::PAGE_W-1:0]] <= free_frame;
                        listed_reg <= listed_reg + ssa_pkg::LIST_W'(1);
                        frame_reg  <= free_frame;
                        sw_reg     <= '0;
                        state_reg  <= S_INIT;
                    end
                end
                S_INIT: begin
                    sw_reg <= sw_reg + ssa_pkg::CNT_W'(1);
                    if (sw_reg == ssa_pkg::CNT_W'(ssa_pkg::SLOTS_PER_PAGE - 1)) begin
                        state_reg <= S_POP;
                    end
                end
                S_POP: begin
                    res_page_reg <= frame_reg;
                    if (pop_cnt == '0) begin
                        state_reg <= S_RESP;
                    end else begin
                        state_reg <= S_POP_DONE;
                    end
                end
                S_POP_DONE: begin
                    fsc_reg[frame_reg] <= pop_cnt - ssa_pkg::CNT_W'(1);
                    res_slot_reg       <= stk_rdata;
                    state_reg          <= S_RESP;
                end
                S_REL_CHK: begin
                    if (free_rdata) begin
                        res_status_reg <= ssa_pkg::ST_ALREADY_FREE;
                        state_reg      <= S_RESP;
                    end else begin
                        fsc_reg[pid_reg] <= rel_cnt + ssa_pkg::CNT_W'(1);
                        if (rel_cnt + ssa_pkg::CNT_W'(1) >= cap_reg[pid_reg] &&
                            !(keep_reg && listed_reg == ssa_pkg::LIST_W'(1))) begin
                            idx_reg   <= '0;
                            state_reg <= S_FIND;
                        end else begin
                            state_reg <= S_RESP;
                        end
                    end
                end
                S_COMPACT: begin
                    if (idx_plus < listed_reg) begin
                        order_reg[idx_reg[ssa_pkg::PAGE_W-1:0]] <= next_frame;
                        idx_reg <= idx_plus;
                    end else begin
                        // drop the emptied page and free its frame
                        listed_reg        <= listed_reg - ssa_pkg::LIST_W'(1);
                        busy_reg[pid_reg] <= 1'b0;
                        res_rel_reg       <= 1'b1;
                        state_reg         <= S_RESP;
                    end
                end
                S_RESP: begin
                    if (!m_valid_reg || m_axis_tready) begin
                        m_valid_reg    <= 1'b1;
                        out_status_reg <= res_status_reg;
                        out_page_reg   <= res_page_reg;
                        out_slot_reg   <= res_slot_reg;
                        out_rel_reg    <= res_rel_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `SSA_CHECK(a_listed_matches_busy, $countones(busy_reg) == int'(listed_reg), "list count and busy frames disagree")
    `SSA_CHECK(a_listed_bound, listed_reg <= ssa_pkg::LIST_W'(NP), "page list overflow")
    `SSA_CHECK_NEXT(a_accept_starts, s_accept, state_reg != S_IDLE, "request accepted but sequencer idle")
    `SSA_CHECK(a_fail_no_grant, !m_valid_reg || out_status_reg == ssa_pkg::ST_OK || (out_page_reg == '0 && out_slot_reg == '0 && !out_rel_reg), "failed request carries a grant")

endmodule

@@ hw/rtl/ssa_slot_mem.sv @@
`timescale 1ns / 1ps
module ssa_slot_mem (
    input  logic                      aclk,
    input  ssa_pkg::mem_req_t         req,
    output logic [ssa_pkg::SLOT_W-1:0] stk_rdata,
    output logic                      free_rdata
);

    localparam int DEPTH = ssa_pkg::MAX_PAGES * ssa_pkg::SLOTS_PER_PAGE;

    logic [ssa_pkg::SLOT_W-1:0] stk_mem [DEPTH];
    logic                       free_mem [DEPTH];
    logic [ssa_pkg::SLOT_W-1:0] stk_rdata_reg;
    logic                       free_rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.stk_we) begin
            stk_mem[req.stk_waddr] <= req.stk_wdata;
        end
        stk_rdata_reg <= stk_mem[req.stk_raddr];
    end

    always_ff @(posedge aclk) begin
        if (req.free_we) begin
            free_mem[req.free_waddr] <= req.free_wdata;
        end
        free_rdata_reg <= free_mem[req.free_raddr];
    end

    assign stk_rdata  = stk_rdata_reg;
    assign free_rdata = free_rdata_reg;

endmodule
